FILE: src/sti_pkg.sv
// Package for the segment/triangle intersection block.
// Holds request and result struct types; no dependencies.
package sti_pkg;

    localparam int unsigned FieldBits = 48;
    localparam int unsigned OutBits   = 17;

    typedef struct packed {
        logic [FieldBits-1:0] point_p;
        logic [FieldBits-1:0] point_q;
        logic [FieldBits-1:0] vertex_a;
        logic [FieldBits-1:0] vertex_b;
        logic [FieldBits-1:0] vertex_c;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [OutBits-1:0] param_t;
        logic [OutBits-1:0] bary_u;
        logic [OutBits-1:0] bary_v;
        logic [OutBits-1:0] bary_w;
    } t_res;

endpackage

FILE: src/sti_div.sv
// Pipelined restoring divider stage chain: floor(num * 2^FB / den), num <= den.
// Depends on nothing; one quotient bit per register stage.
module sti_div #(
    parameter int unsigned NW = 64,
    parameter int unsigned FB = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic [FB:0]   o_q
);
    logic [NW-1:0] r_rem [FB];
    logic [NW-1:0] r_den [FB];
    logic [FB:0]   r_q   [FB+1];
    logic [NW:0]   n_sh  [FB+1];
    logic [NW-1:0] n_dn  [FB+1];
    logic [FB:0]   n_qp  [FB+1];
    logic [NW:0]   n_df  [FB+1];
    logic          n_ge  [FB+1];

    always_comb begin
        n_sh[0] = {1'b0, i_num};
        n_dn[0] = i_den;
        n_qp[0] = '0;
        for (int i = 1; i <= FB; i++) begin
            n_sh[i] = {r_rem[i-1], 1'b0};
            n_dn[i] = r_den[i-1];
            n_qp[i] = r_q[i-1];
        end
        for (int i = 0; i <= FB; i++) begin
            n_ge[i] = n_sh[i] >= {1'b0, n_dn[i]};
            n_df[i] = n_sh[i] - {1'b0, n_dn[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < FB; i++) begin
                r_den[i] <= n_dn[i];
                r_rem[i] <= n_ge[i] ? n_df[i][NW-1:0] : n_sh[i][NW-1:0];
            end
            for (int i = 0; i <= FB; i++) begin
                r_q[i] <= {n_qp[i][FB-1:0], n_ge[i]};
            end
        end
    end

    assign o_q = r_q[FB];
endmodule

FILE: src/segment_triangle_intersect.sv
// Top level of the segment/triangle intersection pipeline.
// Depends on sti_pkg and sti_div.
//
//  channel | valid    | stall    | payload
//  request | i_valid  | o_stall  | i_req  (t_req)
//  result  | o_valid  | i_stall  | o_res  (t_res)
//
// One request per cycle while no downstream stall holds the pipe.
// Depth is set by the product stages and the one-bit-per-stage dividers.
// Reset clears only the valid bits. A downstream stall freezes the whole pipe;
// o_stall follows i_stall only while the output stage holds a result.
module segment_triangle_intersect
    import sti_pkg::*;
#(
    parameter int unsigned COORD_BITS    = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);
    localparam int unsigned CW = COORD_BITS + 1;       // differences
    localparam int unsigned PW = 2 * CW + 2;           // cross products
    localparam int unsigned DW = PW + CW + 3;          // dot products
    localparam int unsigned FB = FRACTION_BITS;
    localparam int unsigned LAT = FB + 1;

    typedef logic signed [CW-1:0] t_c;
    typedef logic signed [PW-1:0] t_p;
    typedef logic signed [DW-1:0] t_d;

    logic adv;
    logic [4:0] r_v;
    logic [LAT-1:0] r_dv;
    logic [LAT-1:0] r_dh;

    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    function automatic t_c comp(input logic [FieldBits-1:0] f, input int k);
        logic [3*COORD_BITS-1:0] ext;
        logic [COORD_BITS-1:0] raw;
        ext = (3*COORD_BITS)'(f);
        raw = ext[k*COORD_BITS +: COORD_BITS];
        return t_c'($signed(raw));
    endfunction

    // stage 1: differences
    t_c r_ab [3], r_ac [3], r_qp [3], r_ap [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= comp(i_req.vertex_b, k) - comp(i_req.vertex_a, k);
                r_ac[k] <= comp(i_req.vertex_c, k) - comp(i_req.vertex_a, k);
                r_qp[k] <= comp(i_req.point_p, k) - comp(i_req.point_q, k);
                r_ap[k] <= comp(i_req.point_p, k) - comp(i_req.vertex_a, k);
            end
        end
    end

    // stage 2: cross products n = ab x ac, e = qp x ap
    t_p r_n [3], r_e [3];
    t_c r2_ab [3], r2_ac [3], r2_qp [3], r2_ap [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= t_p'(r_ab[(k+1)%3] * r_ac[(k+2)%3])
                        - t_p'(r_ab[(k+2)%3] * r_ac[(k+1)%3]);
                r_e[k] <= t_p'(r_qp[(k+1)%3] * r_ap[(k+2)%3])
                        - t_p'(r_qp[(k+2)%3] * r_ap[(k+1)%3]);
                r2_ab[k] <= r_ab[k];
                r2_ac[k] <= r_ac[k];
                r2_qp[k] <= r_qp[k];
                r2_ap[k] <= r_ap[k];
            end
        end
    end

    // stage 3: partial products
    t_d r_pd [3], r_pt [3], r_pv [3], r_pw [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_pd[k] <= t_d'(r2_qp[k] * r_n[k]);
                r_pt[k] <= t_d'(r2_ap[k] * r_n[k]);
                r_pv[k] <= t_d'(r2_ac[k] * r_e[k]);
                r_pw[k] <= t_d'(r2_ab[k] * r_e[k]);
            end
        end
    end

    // stage 4: sums
    t_d r_d, r_t, r_vv, r_w;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d  <= r_pd[0] + r_pd[1] + r_pd[2];
            r_t  <= r_pt[0] + r_pt[1] + r_pt[2];
            r_vv <= r_pv[0] + r_pv[1] + r_pv[2];
            r_w  <= t_d'(0) - (r_pw[0] + r_pw[1] + r_pw[2]);
        end
    end

    // stage 5: bounds
    logic r_hit;
    t_d r5_d, r5_t, r5_v, r5_w;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= (r_d > 0) && (r_t >= 0) && (r_t <= r_d) && (r_vv >= 0)
                && (r_vv <= r_d) && (r_w >= 0) && ((r_vv + r_w) <= r_d);
            r5_d <= r_d;
            r5_t <= r_t;
            r5_v <= r_vv;
            r5_w <= r_w;
        end
    end

    logic [FB:0] q_t, q_v, q_w;
    logic [DW-1:0] den;
    assign den = r_hit ? r5_d : DW'(1);

    sti_div #(.NW(DW), .FB(FB)) u_div_t (.i_clk, .i_en(adv),
        .i_num(r_hit ? r5_t : '0), .i_den(den), .o_q(q_t));
    sti_div #(.NW(DW), .FB(FB)) u_div_v (.i_clk, .i_en(adv),
        .i_num(r_hit ? r5_v : '0), .i_den(den), .o_q(q_v));
    sti_div #(.NW(DW), .FB(FB)) u_div_w (.i_clk, .i_en(adv),
        .i_num(r_hit ? r5_w : '0), .i_den(den), .o_q(q_w));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dh <= {r_dh[LAT-2:0], r_hit};
        end
    end

    // output stage
    t_res r_res;
    logic [FB+1:0] one_m;
    always_comb begin
        one_m = (FB+2)'(1) << FB;
        one_m = one_m - {1'b0, q_v} - {1'b0, q_w};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res.hit     <= r_dh[LAT-1];
            r_res.param_t <= OutBits'(r_dh[LAT-1] ? q_t : '0);
            r_res.bary_v  <= OutBits'(r_dh[LAT-1] ? q_v : '0);
            r_res.bary_w  <= OutBits'(r_dh[LAT-1] ? q_w : '0);
            r_res.bary_u  <= OutBits'(r_dh[LAT-1] ? one_m : '0);
        end
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v  <= {r_v[3:0], i_valid};
            r_dv <= {r_dv[LAT-2:0], r_v[4]};
            r_ov <= r_dv[LAT-1];
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
endmodule

FILE: bench/tb_segment_triangle_intersect.sv
// Testbench for segment_triangle_intersect: drives segment/triangle requests
// under random idling and checks each result against an in-bench predictor.
// Depends on sti_pkg and the segment_triangle_intersect RTL.
module tb_segment_triangle_intersect;
    import sti_pkg::*;

    localparam int CoordBits = 16;
    localparam int FracBits  = 16;
    localparam int Latency   = 6 + FracBits + 1;
    localparam int WatchLimit = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    t_req i_req = '0;
    logic o_stall, o_valid;
    t_res o_res;

    t_res expected_q[$];
    int   error_count = 0;
    int   checked_count = 0;
    int   hit_count = 0;
    int   idle_cycles = 0;
    int   send_pct = 0;
    int   recv_pct = 0;
    bit   hold_off = 0;
    bit   timed_out = 0;

    segment_triangle_intersect #(.COORD_BITS(CoordBits), .FRACTION_BITS(FracBits)) i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req, .o_valid, .i_stall, .o_res
    );

    always #5 i_clk = ~i_clk;

    typedef logic signed [127:0] t_wide;

    function automatic t_wide coord(logic [47:0] packed_v, int k);
        logic signed [15:0] raw;
        raw = packed_v[k*CoordBits +: CoordBits];
        return t_wide'(raw);
    endfunction

    function automatic t_wide dot(t_wide x[3], t_wide y[3]);
        return x[0]*y[0] + x[1]*y[1] + x[2]*y[2];
    endfunction

    function automatic void cross3(input t_wide x[3], input t_wide y[3], output t_wide r[3]);
        r[0] = x[1]*y[2] - x[2]*y[1];
        r[1] = x[2]*y[0] - x[0]*y[2];
        r[2] = x[0]*y[1] - x[1]*y[0];
    endfunction

    function automatic t_res predict(t_req rq);
        t_wide ab[3], ac[3], qp[3], ap[3], n[3], e[3];
        t_wide d, t, v, w;
        logic [63:0] ft, fv, fw;
        t_res r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            ab[k] = coord(rq.vertex_b, k) - coord(rq.vertex_a, k);
            ac[k] = coord(rq.vertex_c, k) - coord(rq.vertex_a, k);
            qp[k] = coord(rq.point_p, k) - coord(rq.point_q, k);
            ap[k] = coord(rq.point_p, k) - coord(rq.vertex_a, k);
        end
        cross3(ab, ac, n);
        d = dot(qp, n);
        if (d <= 0) return r;
        t = dot(ap, n);
        if (t < 0 || t > d) return r;
        cross3(qp, ap, e);
        v = dot(ac, e);
        if (v < 0 || v > d) return r;
        w = -dot(ab, e);
        if (w < 0 || v + w > d) return r;
        ft = 64'((t <<< FracBits) / d);
        fv = 64'((v <<< FracBits) / d);
        fw = 64'((w <<< FracBits) / d);
        r.hit = 1'b1;
        r.param_t = ft[OutBits-1:0];
        r.bary_u = OutBits'((64'd1 << FracBits) - fv - fw);
        r.bary_v = fv[OutBits-1:0];
        r.bary_w = fw[OutBits-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_res.hit, 0);
            end else begin
                want = expected_q.pop_front();
                checked_count++;
                if (want.hit) hit_count++;
                if (o_res.hit !== want.hit) report_mismatch("hit", o_res.hit, want.hit);
                if (o_res.param_t !== want.param_t)
                    report_mismatch("param_t", o_res.param_t, want.param_t);
                if (o_res.bary_u !== want.bary_u)
                    report_mismatch("bary_u", o_res.bary_u, want.bary_u);
                if (o_res.bary_v !== want.bary_v)
                    report_mismatch("bary_v", o_res.bary_v, want.bary_v);
                if (o_res.bary_w !== want.bary_w)
                    report_mismatch("bary_w", o_res.bary_w, want.bary_w);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WatchLimit && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired");
            $display("tb_segment_triangle_intersect: done, errors");
            $finish;
        end
    end

    function automatic logic [47:0] pack3(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [47:0] rand_vec();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] near_vec(int span);
        return pack3($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                     $urandom_range(2*span) - span);
    endfunction

    task automatic send(t_req rq);
        while (send_pct > 0 && $urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= rq;
        expected_q.push_back(predict(rq));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // directed rows: mostly a stock triangle at z=0, segments around it
    localparam logic [47:0] VA = 48'h0000_0000_0000;
    localparam logic [47:0] VB = 48'h0000_0000_0100;
    localparam logic [47:0] VC = 48'h0000_0100_0000;

    typedef struct {
        t_req rq;
        bit   typed;
        t_res want;
    } t_row;

    t_row rows[$];

    task automatic add_row(logic [47:0] p, logic [47:0] q, logic [47:0] a,
                           logic [47:0] b, logic [47:0] c, bit typed, t_res want);
        t_row r;
        r.rq = '{point_p: p, point_q: q, vertex_a: a, vertex_b: b, vertex_c: c};
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    task automatic gen_hit(int span);
        t_req rq;
        int s;
        s = $urandom_range(span, 1);
        rq.vertex_a = near_vec(s);
        rq.vertex_b = near_vec(s);
        rq.vertex_c = near_vec(s);
        rq.point_p = near_vec(s);
        rq.point_q = near_vec(s);
        if (!predict(rq).hit) begin
            // mirror the segment to flip the facing
            {rq.point_p, rq.point_q} = {rq.point_q, rq.point_p};
        end
        send(rq);
    endtask

    initial begin
        t_res miss;
        t_req rq;
        int phase_items;
        miss = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(pack3(64, 64, 256), pack3(64, 64, -256), VA, VB, VC, 1'b0, miss);
        add_row(pack3(64, 64, -256), pack3(64, 64, 256), VA, VB, VC, 1'b1, miss);
        add_row(pack3(0, 0, 256), pack3(256, 0, 256), VA, VB, VC, 1'b1, miss);
        add_row(pack3(0, 0, 0), pack3(0, 0, -256), VA, VB, VC, 1'b0, miss);
        add_row(pack3(0, 0, 256), pack3(0, 0, 0), VA, VB, VC, 1'b0, miss);
        add_row(pack3(256, 0, 256), pack3(256, 0, -256), VA, VB, VC, 1'b0, miss);
        add_row(pack3(0, 256, 256), pack3(0, 256, -256), VA, VB, VC, 1'b0, miss);
        add_row(pack3(128, 128, 256), pack3(128, 128, -256), VA, VB, VC, 1'b0, miss);
        add_row(pack3(200, 200, 256), pack3(200, 200, -256), VA, VB, VC, 1'b1, miss);
        add_row(pack3(64, 64, 256), pack3(64, 64, -256), VA, VB, VB, 1'b1, miss);
        add_row(pack3(64, 64, 512), pack3(64, 64, 256), VA, VB, VC, 1'b1, miss);
        add_row('0, '0, '0, '0, '0, 1'b1, miss);
        add_row('1, '1, '1, '1, '1, 1'b1, miss);
        add_row(pack3(0, 0, 32767), pack3(0, 0, -32768), pack3(-32768, -32768, 0),
                pack3(32767, -32768, 0), pack3(-32768, 32767, 0), 1'b0, miss);
        add_row(pack3(-32768, 32767, 32767), pack3(32767, -32768, -32768),
                pack3(-32768, -32768, 0), pack3(32767, -32768, 0),
                pack3(-32768, 32767, 0), 1'b0, miss);
        add_row(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h5555_5555_5555,
                48'hAAAA_AAAA_AAAA, 48'hFFFF_0000_FFFF, 1'b0, miss);

        foreach (rows[i]) begin
            if (rows[i].typed && predict(rows[i].rq) !== rows[i].want)
                report_mismatch("directed row", i, 0);
            send(rows[i].rq);
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 77; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 77; end
                3: begin send_pct = 30; recv_pct = 30; end
                default: begin send_pct = 0; recv_pct = 0; end
            endcase
            phase_items = (ph == 4) ? 50 : 150;
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3 * Latency) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < phase_items; n++) begin
                if ($urandom_range(9) < 7) begin
                    gen_hit($urandom_range(3) == 0 ? 32767 : 1024);
                end else begin
                    rq.point_p = rand_vec();
                    rq.point_q = rand_vec();
                    rq.vertex_a = rand_vec();
                    rq.vertex_b = rand_vec();
                    rq.vertex_c = rand_vec();
                    send(rq);
                end
            end
        end

        i_valid <= 1'b0;
        send_pct = 0;
        recv_pct = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (Latency + 5) @(posedge i_clk);

        $display("checked %0d results, %0d of them hits, over five idling phases",
                 checked_count, hit_count);
        if (error_count == 0) begin
            $display("tb_segment_triangle_intersect: done, clean");
        end else begin
            $display("tb_segment_triangle_intersect: done, errors");
        end
        $finish;
    end
endmodule
